// File: rtl/eurp_pkg.sv
`default_nettype none
package eurp_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int SINE_DEPTH_DEF = 1024;

    localparam int TRIG_SHIFT = 14;
    localparam int TRIG_HALF  = 8192;
    localparam int QUARTER    = 16384;

    localparam int OFFSET_Z_RST   = 40960;
    localparam int LENS_SCALE_RST = 1560381;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_ANGLE_X    = 3'd0,
        REG_ANGLE_Y    = 3'd1,
        REG_ANGLE_Z    = 3'd2,
        REG_OFFSET_X   = 3'd3,
        REG_OFFSET_Y   = 3'd4,
        REG_OFFSET_Z   = 3'd5,
        REG_LENS_SCALE = 3'd6,
        REG_SPARE      = 3'd7
    } t_reg_index;

endpackage
`default_nettype wire

// File: rtl/euler_rotate_perspective_project_unit.sv
`default_nettype none
// Channel   Dir  Handshake                    Payload (lowest bit first)
// s         in   i_s_tvalid / o_s_tready      vertex_x, vertex_y, vertex_z
// m         out  o_m_tvalid / i_m_tready      screen_x, screen_y; tuser behind_camera
// cfg       in   i_cfg_valid / o_cfg_ready    register index, write data
//
// One vertex enters per clock while o_s_tready is high; a result passes through the
// rotation and multiply stages, the one-bit-per-stage restoring divider and the
// output register.
// The whole pipeline freezes while the output register holds an untaken result.
// The sine/cosine sweep over the quarter-wave ROM (six reads, one per cycle)
// holds off input after any angle write and after reset.
module euler_rotate_perspective_project_unit
    import eurp_pkg::*;
#(
    parameter int COORD_BITS       = COORD_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_s_tvalid,
    output logic                                      o_s_tready,
    // vertex_x, vertex_y, vertex_z, zero padded
    input  wire logic [((3*COORD_BITS+7)/8)*8-1:0]    i_s_tdata,
    output logic                                      o_m_tvalid,
    input  wire logic                                 i_m_tready,
    // screen_x, screen_y, zero padded
    output logic [((2*COORD_BITS+7)/8)*8-1:0]         o_m_tdata,
    // behind_camera
    output logic                                      o_m_tuser,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [2:0]                           i_cfg_index,
    input  wire logic [COORD_BITS-1:0]                i_cfg_data
);

    localparam int C   = COORD_BITS;
    localparam int D   = SINE_TABLE_DEPTH;
    localparam int W   = C + 4;          // headroom for three rotations plus offset
    localparam int P   = W + 16;         // product width
    localparam int NW  = W + C;          // numerator width
    localparam int IW  = $clog2(D + 1);
    localparam int ODW = ((2*C+7)/8)*8;

    // ---------------- configuration registers ----------------
    logic        [15:0]  r_angle [0:2];
    logic signed [C-1:0] r_off_x, r_off_y, r_off_z;
    logic        [C-1:0] r_lens;
    logic                w_cfg_wr;
    logic                w_angle_wr;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;
    assign w_angle_wr  = w_cfg_wr && (i_cfg_index == REG_ANGLE_X ||
                         i_cfg_index == REG_ANGLE_Y || i_cfg_index == REG_ANGLE_Z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle[0] <= '0;
            r_angle[1] <= '0;
            r_angle[2] <= '0;
            r_off_x    <= '0;
            r_off_y    <= '0;
            r_off_z    <= C'(OFFSET_Z_RST);
            r_lens     <= C'(LENS_SCALE_RST);
        end else if (w_cfg_wr) begin
            case (t_reg_index'(i_cfg_index))
                REG_ANGLE_X:    r_angle[0] <= i_cfg_data[15:0];
                REG_ANGLE_Y:    r_angle[1] <= i_cfg_data[15:0];
                REG_ANGLE_Z:    r_angle[2] <= i_cfg_data[15:0];
                REG_OFFSET_X:   r_off_x    <= i_cfg_data;
                REG_OFFSET_Y:   r_off_y    <= i_cfg_data;
                REG_OFFSET_Z:   r_off_z    <= i_cfg_data;
                REG_LENS_SCALE: r_lens     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- sine/cosine sweep ----------------
    logic [14:0] w_rom [0:D];
    for (genvar g = 0; g <= D; g++) begin : g_rom
        // sine series at pi/2 * g / D in Q30, rounded to unsigned Q1.14
        localparam longint unsigned AX  = (64'd1686629713 * 64'(g)) / 64'(D);
        localparam longint unsigned AX2 = (AX * AX) >> 30;
        localparam longint unsigned T1  = ((AX  * AX2) >> 30) / 64'd6;
        localparam longint unsigned T2  = ((T1  * AX2) >> 30) / 64'd20;
        localparam longint unsigned T3  = ((T2  * AX2) >> 30) / 64'd42;
        localparam longint unsigned T4  = ((T3  * AX2) >> 30) / 64'd72;
        localparam longint unsigned T5  = ((T4  * AX2) >> 30) / 64'd110;
        localparam longint unsigned T6  = ((T5  * AX2) >> 30) / 64'd156;
        localparam longint unsigned T7  = ((T6  * AX2) >> 30) / 64'd210;
        localparam longint unsigned T8  = ((T7  * AX2) >> 30) / 64'd272;
        localparam longint unsigned T9  = ((T8  * AX2) >> 30) / 64'd342;
        localparam longint unsigned T10 = ((T9  * AX2) >> 30) / 64'd420;
        localparam longint unsigned T11 = ((T10 * AX2) >> 30) / 64'd506;
        localparam longint unsigned T12 = ((T11 * AX2) >> 30) / 64'd600;
        localparam longint SUM = longint'(AX) - longint'(T1) + longint'(T2)
                               - longint'(T3) + longint'(T4) - longint'(T5)
                               + longint'(T6) - longint'(T7) + longint'(T8)
                               - longint'(T9) + longint'(T10) - longint'(T11)
                               + longint'(T12);
        localparam longint ENT = (SUM < 0) ? 64'sd0 : ((SUM + 64'sd32768) >>> 16);
        localparam logic [14:0] ROM_Q = 15'((ENT > 64'sd16384) ? 64'sd16384 : ENT);
        assign w_rom[g] = ROM_Q;
    end

    logic              r_lut_busy, n_lut_busy;
    logic [2:0]        r_lut_cnt, n_lut_cnt;
    logic              r_rd_vld;
    logic [2:0]        r_rd_tag;
    logic              r_rd_neg;
    logic [14:0]       r_rom_q;
    logic signed [15:0] r_trig [0:5];   // sin x, cos x, sin y, cos y, sin z, cos z
    logic [15:0]       w_lut_ang;
    logic [31:0]       w_lut_prod;
    logic [IW-1:0]     w_lut_idx;
    logic [IW-1:0]     w_lut_addr;

    always_comb begin
        w_lut_ang  = r_angle[r_lut_cnt[2:1]] + (r_lut_cnt[0] ? 16'(QUARTER) : 16'd0);
        w_lut_prod = 32'(w_lut_ang[13:0]) * 32'(D);
        w_lut_idx  = IW'(w_lut_prod >> TRIG_SHIFT);
        w_lut_addr = w_lut_ang[14] ? IW'(D) - w_lut_idx : w_lut_idx;
        n_lut_busy = r_lut_busy;
        n_lut_cnt  = r_lut_cnt;
        if (w_angle_wr) begin
            n_lut_busy = 1'b1;
            n_lut_cnt  = '0;
        end else if (r_lut_busy) begin
            if (r_lut_cnt == 3'd5) begin
                n_lut_busy = 1'b0;
            end else begin
                n_lut_cnt = r_lut_cnt + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lut_busy <= 1'b1;
            r_lut_cnt  <= '0;
            r_rd_vld   <= 1'b0;
        end else begin
            r_lut_busy <= n_lut_busy;
            r_lut_cnt  <= n_lut_cnt;
            r_rd_vld   <= r_lut_busy && !w_angle_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rom_q  <= w_rom[w_lut_addr];
        r_rd_tag <= r_lut_cnt;
        r_rd_neg <= w_lut_ang[15];
        if (r_rd_vld) begin
            r_trig[r_rd_tag] <= r_rd_neg ? -16'(r_rom_q) : 16'(r_rom_q);
        end
    end

    // ---------------- datapath pipeline ----------------
    function automatic logic signed [W-1:0] rnd(input logic signed [P:0] acc);
        logic signed [P:0] t;
        t = acc + (P+1)'(TRIG_HALF);
        return t[W+TRIG_SHIFT-1:TRIG_SHIFT];
    endfunction

    logic w_en;
    logic r_out_vld;

    assign w_en       = !r_out_vld || i_m_tready;
    assign o_s_tready = w_en && !r_lut_busy && !r_rd_vld;

    logic               r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8, r_v9, r_v10;
    logic signed [W-1:0] r_x1, r_y1, r_z1, r_x2, r_x3, r_y3, r_z3;
    logic signed [W-1:0] r_y4, r_x5, r_y5, r_z5, r_z6, r_x7, r_y7, r_z7;
    logic signed [W-1:0] r_x8, r_y8, r_z8;
    logic signed [P-1:0] r_pa, r_pb, r_pc, r_pd, r_pe, r_pf, r_pg, r_ph;
    logic signed [P-1:0] r_pi, r_pj, r_pk, r_pl;
    logic               r_beh9, r_negx9, r_negy9, r_beh10, r_negx10, r_negy10;
    logic [W-1:0]       r_magx9, r_magy9, r_dz9, r_dz10;
    logic [NW-1:0]      r_numx10, r_numy10;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            {r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8, r_v9, r_v10} <= '0;
        end else if (w_en) begin
            r_v1  <= i_s_tvalid && o_s_tready;
            r_v2  <= r_v1;
            r_v3  <= r_v2;
            r_v4  <= r_v3;
            r_v5  <= r_v4;
            r_v6  <= r_v5;
            r_v7  <= r_v6;
            r_v8  <= r_v7;
            r_v9  <= r_v8;
            r_v10 <= r_v9;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // capture vertex
            r_x1 <= W'(signed'(i_s_tdata[C-1:0]));
            r_y1 <= W'(signed'(i_s_tdata[2*C-1:C]));
            r_z1 <= W'(signed'(i_s_tdata[3*C-1:2*C]));
            // about x
            r_x2 <= r_x1;
            r_pa <= P'(r_y1) * P'(r_trig[1]);
            r_pb <= P'(r_z1) * P'(r_trig[0]);
            r_pc <= P'(r_y1) * P'(r_trig[0]);
            r_pd <= P'(r_z1) * P'(r_trig[1]);
            r_x3 <= r_x2;
            r_y3 <= rnd((P+1)'(r_pa) - (P+1)'(r_pb));
            r_z3 <= rnd((P+1)'(r_pc) + (P+1)'(r_pd));
            // about y, original x and z from the x rotation
            r_y4 <= r_y3;
            r_pe <= P'(r_z3) * P'(r_trig[2]);
            r_pf <= P'(r_x3) * P'(r_trig[3]);
            r_pg <= P'(r_z3) * P'(r_trig[3]);
            r_ph <= P'(r_x3) * P'(r_trig[2]);
            r_y5 <= r_y4;
            r_x5 <= rnd((P+1)'(r_pe) + (P+1)'(r_pf));
            r_z5 <= rnd((P+1)'(r_pg) - (P+1)'(r_ph));
            // about z
            r_z6 <= r_z5;
            r_pi <= P'(r_x5) * P'(r_trig[5]);
            r_pj <= P'(r_y5) * P'(r_trig[4]);
            r_pk <= P'(r_x5) * P'(r_trig[4]);
            r_pl <= P'(r_y5) * P'(r_trig[5]);
            r_z7 <= r_z6;
            r_x7 <= rnd((P+1)'(r_pi) - (P+1)'(r_pj));
            r_y7 <= rnd((P+1)'(r_pk) + (P+1)'(r_pl));
            // translate
            r_x8 <= r_x7 + W'(r_off_x);
            r_y8 <= r_y7 + W'(r_off_y);
            r_z8 <= r_z7 + W'(r_off_z);
            // depth test and magnitudes
            r_beh9  <= (r_z8 <= 0);
            r_negx9 <= r_x8[W-1];
            r_negy9 <= r_y8[W-1];
            r_magx9 <= r_x8[W-1] ? W'(-r_x8) : W'(r_x8);
            r_magy9 <= r_y8[W-1] ? W'(-r_y8) : W'(r_y8);
            r_dz9   <= W'(r_z8);
            // numerators
            r_beh10  <= r_beh9;
            r_negx10 <= r_negx9;
            r_negy10 <= r_negy9;
            r_dz10   <= r_dz9;
            r_numx10 <= NW'(r_magx9) * NW'(r_lens);
            r_numy10 <= NW'(r_magy9) * NW'(r_lens);
        end
    end

    // ---------------- restoring divider, one quotient bit per stage ----------------
    logic          r_dv_vld  [0:C];
    logic          r_dv_beh  [0:C];
    logic          r_dv_negx [0:C];
    logic          r_dv_negy [0:C];
    logic          r_dv_ovfx [0:C];
    logic          r_dv_ovfy [0:C];
    logic [W-1:0]  r_dv_dz   [0:C];
    logic [NW-1:0] r_dv_remx [0:C];
    logic [NW-1:0] r_dv_remy [0:C];
    logic [C-1:0]  r_dv_qx   [0:C];
    logic [C-1:0]  r_dv_qy   [0:C];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else if (w_en) begin
            r_dv_vld[0] <= r_v10;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv_beh[0]  <= r_beh10;
            r_dv_negx[0] <= r_negx10;
            r_dv_negy[0] <= r_negy10;
            r_dv_dz[0]   <= r_dz10;
            r_dv_ovfx[0] <= r_numx10 >= (NW'(r_dz10) << C);
            r_dv_ovfy[0] <= r_numy10 >= (NW'(r_dz10) << C);
            r_dv_remx[0] <= r_numx10;
            r_dv_remy[0] <= r_numy10;
            r_dv_qx[0]   <= '0;
            r_dv_qy[0]   <= '0;
        end
    end

    for (genvar j = 1; j <= C; j++) begin : g_div
        logic [NW-1:0] w_sub;
        logic          w_gex, w_gey;
        assign w_sub = NW'(r_dv_dz[j-1]) << (C - j);
        assign w_gex = r_dv_remx[j-1] >= w_sub;
        assign w_gey = r_dv_remy[j-1] >= w_sub;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[j] <= 1'b0;
            end else if (w_en) begin
                r_dv_vld[j] <= r_dv_vld[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv_beh[j]  <= r_dv_beh[j-1];
                r_dv_negx[j] <= r_dv_negx[j-1];
                r_dv_negy[j] <= r_dv_negy[j-1];
                r_dv_ovfx[j] <= r_dv_ovfx[j-1];
                r_dv_ovfy[j] <= r_dv_ovfy[j-1];
                r_dv_dz[j]   <= r_dv_dz[j-1];
                r_dv_remx[j] <= w_gex ? r_dv_remx[j-1] - w_sub : r_dv_remx[j-1];
                r_dv_remy[j] <= w_gey ? r_dv_remy[j-1] - w_sub : r_dv_remy[j-1];
                r_dv_qx[j]   <= r_dv_qx[j-1] | (w_gex ? (C'(1) << (C - j)) : C'(0));
                r_dv_qy[j]   <= r_dv_qy[j-1] | (w_gey ? (C'(1) << (C - j)) : C'(0));
            end
        end
    end

    // ---------------- saturate, sign and output register ----------------
    logic [C-1:0] w_limx, w_limy, w_valx, w_valy;
    logic [C-1:0] r_sx, r_sy;
    logic         r_beh_out;

    always_comb begin
        w_limx = r_dv_negx[C] ? (C'(1) << (C-1)) : ((C'(1) << (C-1)) - C'(1));
        w_limy = r_dv_negy[C] ? (C'(1) << (C-1)) : ((C'(1) << (C-1)) - C'(1));
        w_valx = (r_dv_ovfx[C] || r_dv_qx[C] > w_limx) ? w_limx : r_dv_qx[C];
        w_valy = (r_dv_ovfy[C] || r_dv_qy[C] > w_limy) ? w_limy : r_dv_qy[C];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_dv_vld[C];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_beh_out <= r_dv_beh[C];
            if (r_dv_beh[C]) begin
                r_sx <= '0;
                r_sy <= '0;
            end else begin
                r_sx <= r_dv_negx[C] ? -w_valx : w_valx;
                r_sy <= r_dv_negy[C] ? -w_valy : w_valy;
            end
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = ODW'({r_sy, r_sx});
    assign o_m_tuser  = r_beh_out;

endmodule
`default_nettype wire

// File: rtl/eurp_checker.sv
`default_nettype none
module eurp_checker
    import eurp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              o_s_tready,
    input wire logic                              o_m_tvalid,
    input wire logic                              i_m_tready,
    input wire logic [((2*COORD_BITS+7)/8)*8-1:0] o_m_tdata,
    input wire logic                              o_m_tuser,
    input wire logic                              i_cfg_valid,
    input wire logic                              o_cfg_ready,
    input wire logic [2:0]                        i_cfg_index
);

    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result changed");

    // a point behind the camera carries zero screen values
    a_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata == '0)
        else $error("behind-camera result not zero");

    // an angle write holds off input while sine/cosine refresh
    a_refresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready && (i_cfg_index == REG_ANGLE_X ||
        i_cfg_index == REG_ANGLE_Y || i_cfg_index == REG_ANGLE_Z) |=> !o_s_tready)
        else $error("input accepted during angle refresh");

    // drop results on reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && !o_s_tready)
        else $error("pipeline not cleared by reset");

endmodule

bind euler_rotate_perspective_project_unit eurp_checker #(
    .COORD_BITS(COORD_BITS)
) u_eurp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .i_cfg_valid(i_cfg_valid),
    .o_cfg_ready(o_cfg_ready),
    .i_cfg_index(i_cfg_index)
);
`default_nettype wire

// File: tb/tb_euler_rotate_perspective_project_unit.sv
`default_nettype none
module tb_euler_rotate_perspective_project_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import eurp_pkg::*;

    localparam int CB    = 24;
    localparam int DEPTH = 1024;
    localparam int SW    = ((3*CB+7)/8)*8;
    localparam int MW    = ((2*CB+7)/8)*8;
    localparam int CLAMP_LIMIT = 20000;
    localparam int SETTLE      = CB + 40;

    typedef struct packed {
        logic [CB-1:0] sx;
        logic [CB-1:0] sy;
        logic          behind;
    } t_pixel;

    // Quarter-wave sine built by the same series, kept local to the testbench
    class projection_scoreboard;
        int          sine_q[DEPTH+1];
        logic [15:0] ang[3];
        longint      off[3];
        longint unsigned lens;
        t_pixel      pending[$];
        int          errors;

        function new();
            longint unsigned x, x2, term;
            longint sum, e;
            for (int i = 0; i <= DEPTH; i++) begin
                x = (64'd1686629713 * longint'(i)) / DEPTH;
                x2 = (x * x) >> 30;
                term = x;
                sum = longint'(x);
                for (int k = 1; k <= 12; k++) begin
                    term = ((term * x2) >> 30) / longint'((2*k)*(2*k+1));
                    if (k % 2 == 1) sum -= longint'(term);
                    else sum += longint'(term);
                end
                if (sum < 0) sum = 0;
                e = (sum + 32768) >>> 16;
                if (e > 16384) e = 16384;
                sine_q[i] = int'(e);
            end
            reset_regs();
            errors = 0;
        endfunction

        function void reset_regs();
            ang = '{16'd0, 16'd0, 16'd0};
            off = '{0, 0, longint'(OFFSET_Z_RST)};
            lens = LENS_SCALE_RST;
        endfunction

        function void write_reg(t_reg_index idx, logic [CB-1:0] d);
            case (idx)
                REG_ANGLE_X, REG_ANGLE_Y, REG_ANGLE_Z: ang[int'(idx)] = d[15:0];
                REG_OFFSET_X, REG_OFFSET_Y, REG_OFFSET_Z:
                    off[int'(idx) - 3] = longint'(signed'(d));
                REG_LENS_SCALE: lens = longint'(d);
                default: ;
            endcase
        endfunction

        function int sine(logic [15:0] a);
            int idx, mag;
            idx = (int'(a[13:0]) * DEPTH) >> 14;
            mag = a[14] ? sine_q[DEPTH - idx] : sine_q[idx];
            return a[15] ? -mag : mag;
        endfunction

        function longint blend(longint u, int cu, longint v, int cv);
            return (u * cu + v * cv + 8192) >>> 14;
        endfunction

        function longint divide_axis(longint c, longint z);
            logic [127:0] prod, q;
            logic [127:0] lim;
            bit neg;
            neg = c < 0;
            prod = 128'(neg ? -c : c) * 128'(lens);
            q = prod / 128'(z);
            lim = neg ? 128'(1) << (CB-1) : (128'(1) << (CB-1)) - 1;
            if (q > lim) q = lim;
            return neg ? -longint'(q) : longint'(q);
        endfunction

        function void note_vertex(logic [SW-1:0] d);
            longint x, y, z, t0, t1;
            int s, c;
            t_pixel p;
            x = longint'(signed'(d[CB-1:0]));
            y = longint'(signed'(d[2*CB-1:CB]));
            z = longint'(signed'(d[3*CB-1:2*CB]));
            s = sine(ang[0]); c = sine(ang[0] + 16'h4000);
            t0 = blend(y, c, z, -s); t1 = blend(y, s, z, c); y = t0; z = t1;
            s = sine(ang[1]); c = sine(ang[1] + 16'h4000);
            t0 = blend(z, s, x, c); t1 = blend(z, c, x, -s); x = t0; z = t1;
            s = sine(ang[2]); c = sine(ang[2] + 16'h4000);
            t0 = blend(x, c, y, -s); t1 = blend(x, s, y, c); x = t0; y = t1;
            x += off[0]; y += off[1]; z += off[2];
            if (z <= 0) begin
                p = '{sx: '0, sy: '0, behind: 1'b1};
            end else begin
                p.sx = CB'(divide_axis(x, z));
                p.sy = CB'(divide_axis(y, z));
                p.behind = 1'b0;
            end
            pending.push_back(p);
        endfunction

        function void check_pixel(logic [MW-1:0] d, logic u);
            t_pixel w;
            if (pending.size() == 0) begin
                $display("%0t unexpected result: actual x=%h y=%h behind=%b",
                         $realtime, d[CB-1:0], d[2*CB-1:CB], u);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (d[CB-1:0] !== w.sx) begin
                $display("%0t screen_x: expected %h actual %h", $realtime, w.sx, d[CB-1:0]);
                errors++;
            end
            if (d[2*CB-1:CB] !== w.sy) begin
                $display("%0t screen_y: expected %h actual %h", $realtime, w.sy,
                         d[2*CB-1:CB]);
                errors++;
            end
            if (u !== w.behind) begin
                $display("%0t behind_camera: expected %b actual %b", $realtime, w.behind, u);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_tvalid = 1'b0;
    logic [SW-1:0] i_s_tdata = '0;
    logic i_m_tready = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [2:0] i_cfg_index = '0;
    logic [CB-1:0] i_cfg_data = '0;
    logic o_s_tready, o_m_tvalid, o_m_tuser, o_cfg_ready;
    logic [MW-1:0] o_m_tdata;

    projection_scoreboard board = new();
    bit calm = 1'b0;     // no idling in the final stretch
    int stall_left = 0;
    int quiet_cycles = 0;

    always #6 i_clk = ~i_clk;

    euler_rotate_perspective_project_unit #(.COORD_BITS(CB), .SINE_TABLE_DEPTH(DEPTH)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata),
        .o_m_tuser(o_m_tuser),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Receiver: check each accepted result, stall in random bursts
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) board.check_pixel(o_m_tdata, o_m_tuser);
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                stall_left <= $urandom_range(1, 7) - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: count cycles with no request moving on any channel
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= CLAMP_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Drop valid after each write so that writes never run back to back
    task automatic write_reg(t_reg_index idx, logic [CB-1:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_reg(idx, d);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Hold one vertex until taken, with an optional idle burst first
    task automatic send_vertex(logic [CB-1:0] x, logic [CB-1:0] y, logic [CB-1:0] z);
        if (!calm && $urandom_range(0, 7) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(SW-3*CB){1'b0}}, z, y, x};
        do @(posedge i_clk); while (!o_s_tready);
        board.note_vertex(i_s_tdata);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [CB-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return CB'($urandom);
            1: return CB'($signed($urandom_range(0, 65535)) - 32768);
            2: return {1'b1, {(CB-1){1'b0}}};
            3: return {1'b0, {(CB-1){1'b1}}};
            default: return CB'(int'($urandom_range(0, 200000)) - 100000);
        endcase
    endfunction

    // Mostly vertices of moderate size in front of the camera
    task automatic random_batch(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0)
                send_vertex(rand_coord(), rand_coord(), rand_coord());
            else
                send_vertex(CB'(int'($urandom_range(0, 81920)) - 40960),
                            CB'(int'($urandom_range(0, 81920)) - 40960),
                            CB'(int'($urandom_range(0, 40960)) - 20480));
        end
    endtask

    localparam logic [CB-1:0] MAXC = {1'b0, {(CB-1){1'b1}}};
    localparam logic [CB-1:0] MINC = {1'b1, {(CB-1){1'b0}}};

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: identity rotation, field extremes, behind camera, saturation
        send_vertex('0, '0, '0);
        send_vertex(MAXC, MINC, '0);
        send_vertex(MINC, MAXC, MAXC);
        send_vertex(24'd4096, -24'sd4096, MINC);           // depth negative
        send_vertex('0, '0, -24'sd40960);                  // depth exactly zero
        send_vertex(MAXC, MAXC, -24'sd40959);              // tiny depth, saturate
        send_vertex(MINC, MINC, -24'sd40959);
        send_vertex('1, 24'd1, 24'd1);
        drain();
        write_reg(REG_LENS_SCALE, '0);                     // zero lens scale
        send_vertex(24'd12345, -24'sd999, 24'd4096);
        drain();
        write_reg(REG_LENS_SCALE, '1);
        write_reg(REG_ANGLE_X, 24'h004000);
        write_reg(REG_ANGLE_Y, 24'h00FFFF);
        write_reg(REG_ANGLE_Z, 24'h008000);
        write_reg(REG_SPARE, 24'h123456);                  // ignored index
        send_vertex(24'd4096, 24'd8192, 24'd12288);
        send_vertex(MAXC, MINC, MAXC);
        send_vertex(MINC, MAXC, MINC);
        drain();
        write_reg(REG_OFFSET_X, MAXC);
        write_reg(REG_OFFSET_Y, MINC);
        write_reg(REG_OFFSET_Z, MAXC);
        send_vertex(MAXC, MAXC, MAXC);
        send_vertex(MINC, MINC, MINC);
        drain();
        write_reg(REG_OFFSET_Z, MINC);
        send_vertex(MAXC, MAXC, MAXC);
        drain();

        // Random phases across several register settings
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(REG_ANGLE_X, CB'($urandom_range(0, 65535)));
            write_reg(REG_ANGLE_Y, CB'($urandom_range(0, 65535)));
            write_reg(REG_ANGLE_Z, CB'($urandom_range(0, 65535)));
            write_reg(REG_OFFSET_X, CB'(int'($urandom_range(0, 81920)) - 40960));
            write_reg(REG_OFFSET_Y, (ph == 7) ? '0 : rand_coord());
            write_reg(REG_OFFSET_Z, (ph % 3 == 0) ? rand_coord()
                                    : CB'($urandom_range(8192, 200000)));
            write_reg(REG_LENS_SCALE, (ph == 2) ? '1 : CB'($urandom));
            if (ph == 7) calm = 1'b1;
            random_batch(95);
            drain();
        end

        if (board.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
`default_nettype wire
